[rtl/ugf_pkg.sv]
`default_nettype none

package ugf_pkg;

  // Queue sizes
  localparam int UGF_TX_DEPTH = 64;
  localparam int UGF_RX_DEPTH = 64;

  localparam int BYTE_W = 8;

  // Gap countdown reload after reset
  localparam logic [BYTE_W-1:0] GAP_TICKS_RESET = 8'd4;

  // Register map: word index taken from paddr[2]
  localparam int CFG_AW = 3;
  localparam logic REG_GAP_TICKS = 1'b0;

  // Item commands
  localparam logic [2:0] CMD_HOST_WRITE = 3'd0;
  localparam logic [2:0] CMD_TX_DONE    = 3'd1;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd2;
  localparam logic [2:0] CMD_TICK       = 3'd3;
  localparam logic [2:0] CMD_HOST_READ  = 3'd4;

  // Receive framing mode
  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_BUSY  = 2'd1,
    RX_READY = 2'd2
  } rx_mode_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [BYTE_W-1:0] data_in;
    logic              burst_end;
  } ugf_in_t;

  typedef struct packed {
    logic              accepted;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_data;
    logic              rx_drained;
    logic              frame_ready;
    logic              rx_dropped;
  } ugf_out_t;

endpackage

`default_nettype wire

[rtl/ugf_ram.sv]
`default_nettype none

module ugf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/uart_fifo_with_gap_framing_core.sv]
`default_nettype none

// Buffered UART port with receive gap framing. Every item (host write,
// transmit complete, received byte, tick, host read) is taken one item per
// clock unless in_stall is high, and yields exactly one result: on accept
// the queue pointers and framing state update and the queue RAM read is
// issued alongside the stage 1 register, then the result register captures
// the result; stage 1 exists because the queue RAMs have a registered read
// port. Queue contents are not cleared at reset and need no clearing pass;
// pointers, counts, transmitter state and receive mode are cleared at once.
// gap_ticks is written over the APB port at byte address 0; the frame is
// marked ready on the tick that finds the countdown at zero, i.e. gap_ticks+1
// ticks after the last received byte.
module uart_fifo_with_gap_framing_core #(
  parameter int TX_DEPTH = ugf_pkg::UGF_TX_DEPTH,
  parameter int RX_DEPTH = ugf_pkg::UGF_RX_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // item input
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire ugf_pkg::ugf_in_t          in_data,
  // result output
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      ugf_pkg::ugf_out_t         out_data,
  // configuration
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [ugf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output      logic [31:0]               cfg_prdata,
  output      logic                      cfg_pready
);

  import ugf_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0] gap_ticks_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r <= GAP_TICKS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_GAP_TICKS)) begin
      gap_ticks_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_GAP_TICKS) begin
      cfg_prdata = {{(32 - BYTE_W){1'b0}}, gap_ticks_r};
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------
  logic     s1_valid_r;
  ugf_out_t s1_r;
  logic     s1_byp_r;
  logic     out_valid_r;
  ugf_out_t out_data_r;
  logic     s2_ready;
  logic     s1_fwd;
  logic     in_acc;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_fwd   = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_acc   = in_valid && !in_stall;

  logic is_wr, is_txd, is_rxb, is_tick, is_rd;
  assign is_wr   = in_acc && (in_data.command == CMD_HOST_WRITE);
  assign is_txd  = in_acc && (in_data.command == CMD_TX_DONE);
  assign is_rxb  = in_acc && (in_data.command == CMD_RX_BYTE);
  assign is_tick = in_acc && (in_data.command == CMD_TICK);
  assign is_rd   = in_acc && (in_data.command == CMD_HOST_READ);

  // ---------------------------------------------------------------------
  // Transmit queue and transmitter state
  // ---------------------------------------------------------------------
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt;
  logic [TX_AW-1:0] tx_tail_r, tx_tail_nxt;
  logic [TX_CW-1:0] tx_count_r, tx_count_nxt;
  logic             tx_busy_r, tx_busy_nxt;
  logic             tx_push, tx_pop, tx_byp;
  logic [BYTE_W-1:0] tx_rdata;

  always_comb begin
    tx_push = is_wr && (tx_count_r < TX_FULL);
    tx_pop  = 1'b0;
    tx_busy_nxt = tx_busy_r;
    if (is_wr) begin
      // kick-off sees the byte just pushed
      if (in_data.burst_end && !tx_busy_r && (tx_push || (tx_count_r != '0))) begin
        tx_pop      = 1'b1;
        tx_busy_nxt = 1'b1;
      end
    end else if (is_txd && tx_busy_r) begin
      if (tx_count_r != '0) begin
        tx_pop = 1'b1;
      end else begin
        tx_busy_nxt = 1'b0;
      end
    end
    // pushed and popped in the same item: RAM still holds the old entry
    tx_byp = tx_push && tx_pop && (tx_count_r == '0);

    tx_tail_nxt  = tx_push ? ((tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1) : tx_tail_r;
    tx_head_nxt  = tx_pop  ? ((tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1) : tx_head_r;
    tx_count_nxt = tx_count_r + TX_CW'(tx_push) - TX_CW'(tx_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      tx_count_r <= '0;
      tx_busy_r  <= 1'b0;
    end else begin
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      tx_count_r <= tx_count_nxt;
      tx_busy_r  <= tx_busy_nxt;
    end
  end

  ugf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_push),
    .waddr (tx_tail_r),
    .wdata (in_data.data_in),
    .re    (tx_pop),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  // ---------------------------------------------------------------------
  // Receive queue and gap framing
  // ---------------------------------------------------------------------
  logic [RX_AW-1:0]  rx_head_r, rx_head_nxt;
  logic [RX_AW-1:0]  rx_tail_r, rx_tail_nxt;
  logic [RX_CW-1:0]  rx_count_r, rx_count_nxt;
  rx_mode_t          rx_mode_r, rx_mode_nxt;
  logic [BYTE_W-1:0] gap_timer_r, gap_timer_nxt;
  logic              rx_push, rx_pop, rx_dropped, rx_drained;
  logic [BYTE_W-1:0] rx_rdata;

  // framing mode and gap countdown, next state
  always_comb begin
    rx_mode_nxt   = rx_mode_r;
    gap_timer_nxt = gap_timer_r;
    if (is_rxb) begin
      rx_mode_nxt   = RX_BUSY;
      gap_timer_nxt = gap_ticks_r;
    end else if (is_tick && (rx_mode_r == RX_BUSY)) begin
      if (gap_timer_r != '0) begin
        gap_timer_nxt = gap_timer_r - 1'b1;
      end else begin
        rx_mode_nxt = RX_READY;
      end
    end else if (is_rd && (rx_mode_r == RX_READY) && (rx_count_r <= RX_CW'(1))) begin
      rx_mode_nxt = RX_IDLE;
    end
  end

  // queue actions and flags
  always_comb begin
    rx_push    = is_rxb && (rx_count_r < RX_FULL);
    rx_dropped = is_rxb && !(rx_count_r < RX_FULL);
    rx_pop     = is_rd && (rx_mode_r == RX_READY) && (rx_count_r != '0);
    rx_drained = is_rd && (rx_mode_r == RX_READY) && (rx_count_r <= RX_CW'(1));

    rx_tail_nxt  = rx_push ? ((rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1) : rx_tail_r;
    rx_head_nxt  = rx_pop  ? ((rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1) : rx_head_r;
    rx_count_nxt = rx_count_r + RX_CW'(rx_push) - RX_CW'(rx_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_count_r  <= '0;
      rx_mode_r   <= RX_IDLE;
      gap_timer_r <= '0;
    end else begin
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_count_r  <= rx_count_nxt;
      rx_mode_r   <= rx_mode_nxt;
      gap_timer_r <= gap_timer_nxt;
    end
  end

  ugf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_push),
    .waddr (rx_tail_r),
    .wdata (in_data.data_in),
    .re    (rx_pop),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 1: flags of the item, aligned with the RAM read data
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fwd) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.accepted    <= tx_push;
      s1_r.tx_valid    <= tx_pop;
      s1_r.tx_data     <= in_data.data_in;
      s1_r.rx_valid    <= rx_pop;
      s1_r.rx_data     <= '0;
      s1_r.rx_drained  <= rx_drained;
      s1_r.frame_ready <= (rx_mode_nxt == RX_READY);
      s1_r.rx_dropped  <= rx_dropped;
      s1_byp_r         <= tx_byp;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: result register
  // ---------------------------------------------------------------------
  ugf_out_t res;

  always_comb begin
    res = s1_r;
    if (!s1_r.tx_valid) begin
      res.tx_data = '0;
    end else if (!s1_byp_r) begin
      res.tx_data = tx_rdata;
    end
    res.rx_data = s1_r.rx_valid ? rx_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fwd) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/ugf_checker.sv]
`default_nettype none

module ugf_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ugf_pkg::ugf_out_t out_data
);

  import ugf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // data bytes are zero unless their valid flag is set
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tx_valid || (out_data.tx_data == '0)) &&
                  (out_data.rx_valid || (out_data.rx_data == '0)))
    else $error("data byte without valid flag");

  // a dropped byte leaves the mode busy and touches nothing else
  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_dropped |-> !out_data.accepted && !out_data.tx_valid &&
                                        !out_data.rx_valid && !out_data.frame_ready)
    else $error("dropped byte mixed with other results");

  // after a pop the frame stays ready unless the queue drained
  a_pop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_valid |-> (out_data.frame_ready != out_data.rx_drained))
    else $error("frame_ready disagrees with rx_drained after a read");

endmodule

bind uart_fifo_with_gap_framing_core ugf_checker u_ugf_checker (.*);

`default_nettype wire
